// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, prop)
`endif

`endif

// ===== sv/lurg_pkg.sv =====
// ----------------------------------------------------------------------------
// lurg_pkg
// Shared constants and controller command type for the uniform range
// generator.
// ----------------------------------------------------------------------------
package lurg_pkg;

  localparam logic [31:0] SeedMult = 32'd69069;
  localparam logic [31:0] SeedZero = 32'd259341593;
  localparam logic [31:0] SignBias = 32'h8000_0000;

  localparam logic ReqSigned   = 1'b0;
  localparam logic ReqUnsigned = 1'b1;

  // step commands from the controller to the datapath; load and fin are
  // both high when a new beat is taken in the finish cycle
  typedef struct packed {
    logic load;  // capture request beat
    logic adv;   // advance seed, update stream, form range width
    logic mul;   // width times fraction mantissa
    logic fin;   // finish result into output register
  } ctl_cmd_t;

endpackage

// ===== sv/lurg_ctrl.sv =====
// ----------------------------------------------------------------------------
// lurg_ctrl
// Sequencer for one request: seed step, multiply step, finish step, and the
// output register valid flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lurg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lurg_pkg::ctl_cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSeed = 2'd1;
  localparam logic [1:0] StMul  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free, fin_go, in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fin_go     = (state_q == StFin) && out_free;
  assign in_stall_o = !((state_q == StIdle) || fin_go);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_accept) state_d = StSeed;
      end
      StSeed: state_d = StMul;
      StMul:  state_d = StFin;
      StFin: begin
        if (fin_go) state_d = in_accept ? StSeed : StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_d = fin_go || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o.load = in_accept;
  assign cmd_o.adv  = (state_q == StSeed);
  assign cmd_o.mul  = (state_q == StMul);
  assign cmd_o.fin  = fin_go;
  assign out_valid_o = out_valid_q;

  `ASSERT_CLK(a_accept_starts_seed, in_accept |=> state_q == StSeed)
  `ASSERT_CLK(a_seed_then_mul, state_q == StSeed |=> state_q == StMul)
  `ASSERT_CLK(a_fin_fills_output, fin_go |=> out_valid_q)
  `ASSERT_NEVER(a_no_accept_mid_work, in_accept && (state_q == StSeed || state_q == StMul))
  `ASSERT_NEVER(a_fin_blocked_drops, out_valid_q && out_stall_i && fin_go)

endmodule

// ===== sv/lurg_dpath.sv =====
// ----------------------------------------------------------------------------
// lurg_dpath
// Request registers, stream seeds, LCG step, range scaling multiply,
// truncate and clamp, output payload register.
// ----------------------------------------------------------------------------
module lurg_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lurg_pkg::ctl_cmd_t cmd_i,
  input  logic               req_type_i,
  input  logic [31:0]        range_low_i,
  input  logic [31:0]        range_high_i,
  input  logic               seed_given_i,
  input  logic signed [31:0] seed_in_i,
  output logic [31:0]        rand_value_o,
  output logic signed [31:0] seed_out_o
);

  // stream seeds
  logic [31:0] sstream_q, ustream_q;

  // request registers; bounds are kept in the signed (biased) domain
  logic               type_q, given_q, empty_q;
  logic signed [31:0] lo_q, hi_q;
  logic [31:0]        seed_q;
  logic [32:0]        d_q;
  logic [55:0]        t_q;
  logic [31:0]        rand_value_q, seed_out_q;

  // accept-side bound selection
  logic        swap;
  logic [31:0] lo_sel, hi_sel;

  always_comb begin
    swap   = range_low_i > range_high_i;
    lo_sel = range_low_i;
    hi_sel = range_high_i;
    if (req_type_i == lurg_pkg::ReqUnsigned) begin
      lo_sel = (swap ? range_high_i : range_low_i) ^ lurg_pkg::SignBias;
      hi_sel = (swap ? range_low_i : range_high_i) ^ lurg_pkg::SignBias;
    end
  end

  // seed step
  logic [31:0]        seed_base, seed_adv, seed_new;
  logic               empty;
  logic signed [33:0] width;

  assign seed_base = (seed_q == 32'd0) ? lurg_pkg::SeedZero : seed_q;
  assign seed_adv  = seed_base * lurg_pkg::SeedMult + 32'd1;
  assign empty     = lo_q >= hi_q;
  assign seed_new  = empty ? seed_q : seed_adv;
  assign width     = 34'(hi_q) - 34'(lo_q) + 34'sd1;

  // finish step: h = D*(m+1) + floor(D*m / 2^23), q = floor(h / 2^23)
  logic [56:0]        h;
  logic [33:0]        q;
  logic               exact;
  logic signed [35:0] lo_ext, hi_ext, whole, trunc_v, clamp_v;
  logic [31:0]        value;

  always_comb begin
    h       = 57'(t_q) + 57'(d_q) + 57'(t_q[55:23]);
    q       = h[56:23];
    exact   = (h[22:0] | t_q[22:0]) == 23'd0;
    lo_ext  = 36'(lo_q);
    hi_ext  = 36'(hi_q);
    whole   = lo_ext + signed'({2'b00, q});
    // negative value with no fraction steps down by one
    trunc_v = (whole < 36'sd0 && exact) ? whole - 36'sd1 : whole;
    clamp_v = trunc_v;
    if (trunc_v < lo_ext) clamp_v = lo_ext;
    if (trunc_v > hi_ext) clamp_v = hi_ext;
    value   = empty_q ? lo_q : clamp_v[31:0];
    if (type_q == lurg_pkg::ReqUnsigned) value = value ^ lurg_pkg::SignBias;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sstream_q <= '0;
      ustream_q <= '0;
    end else if (cmd_i.adv) begin
      if (type_q == lurg_pkg::ReqUnsigned) begin
        ustream_q <= seed_new;
      end else if (!given_q) begin
        sstream_q <= seed_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      type_q  <= req_type_i;
      given_q <= seed_given_i;
      lo_q    <= signed'(lo_sel);
      hi_q    <= signed'(hi_sel);
      if (seed_given_i) begin
        seed_q <= seed_in_i;
      end else begin
        seed_q <= (req_type_i == lurg_pkg::ReqUnsigned) ? ustream_q : sstream_q;
      end
    end
    if (cmd_i.adv) begin
      seed_q  <= seed_new;
      empty_q <= empty;
      d_q     <= width[32:0];
    end
    if (cmd_i.mul) begin
      t_q <= 56'(d_q) * 56'(seed_q[31:9]);
    end
    if (cmd_i.fin) begin
      rand_value_q <= value;
      seed_out_q   <= seed_q;
    end
  end

  assign rand_value_o = rand_value_q;
  assign seed_out_o   = signed'(seed_out_q);

endmodule

// ===== sv/lcg_uniform_range_generator.sv =====
// ----------------------------------------------------------------------------
// lcg_uniform_range_generator
// Uniform integer in [low, high] from a 69069 LCG seed, signed or unsigned
// range, with two stored seed streams.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  in      | in_valid_i / in_stall_o | req_type, range_low, range_high,
//          |                         | seed_given, seed_in
//  out     | out_valid_o/out_stall_i | rand_value, seed_out
//
// A request passes through three steps: seed step (32x17 multiply), width times
// mantissa (33x23 multiply), then add, truncate and clamp into the output
// register. The next request can be taken in the finish step, but none is
// taken in the seed or multiply step. A stalled output holds its beat and
// blocks the finish step. Reset clears both streams.
// ----------------------------------------------------------------------------
module lcg_uniform_range_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [31:0]        range_low_i,
  input  logic [31:0]        range_high_i,
  input  logic               seed_given_i,
  input  logic signed [31:0] seed_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        rand_value_o,
  output logic signed [31:0] seed_out_o
);

  lurg_pkg::ctl_cmd_t cmd;

  lurg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lurg_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_type_i   (req_type_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .seed_given_i (seed_given_i),
    .seed_in_i    (seed_in_i),
    .rand_value_o (rand_value_o),
    .seed_out_o   (seed_out_o)
  );

endmodule
